// ===== hw/rtl/rgbm_pkg.sv =====
package rgbm_pkg;

  // default fixed-point format of the pixel channels (UQ5.16)
  localparam int FRAC_BITS_DEF = 16;
  localparam int INT_BITS_DEF  = 5;

  // channel count and code width of the rgbm bytes
  localparam int NCH    = 3;
  localparam int CODE_W = 8;

  // range register
  localparam int RANGE_W = 5;
  localparam logic [RANGE_W-1:0] RANGE_RESET = 5'd9;
  localparam logic [RANGE_W-1:0] RANGE_MIN   = 5'd1;

  // code constants: full scale and full scale squared
  localparam logic [CODE_W-1:0]   CODE_MAX = 8'd255;
  localparam logic [CODE_W-1:0]   CODE_MIN = 8'd1;
  localparam logic [2*CODE_W-1:0] CODE_SQ  = 16'd65025;

  // configuration port: byte address, word index above the two byte bits
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;
  localparam int REG_IDX_W = ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_RANGE = 1'b0;

endpackage

// ===== hw/rtl/rgbm_hdr_pixel_encoder_top.sv =====
// rgbm hdr pixel encoder
// Input channel: an item (in_red_in, in_green_in, in_blue_in, unsigned fixed point with
// FRAC_BITS fraction bits) is taken at a rising edge where start is high and busy is low.
// busy is held low: the pipeline takes one item every clock cycle.
// Result channel: out_strobe is high for one cycle with out_red_out, out_green_out,
// out_blue_out and out_multiplier_out; the receiver must take it in that cycle.
// out_strobe rises once the item has passed every pipeline stage listed below; results leave in
// accept order. Throughput is one item per cycle.
// The depth is set by two restoring dividers of one quotient bit per stage: eight stages
// for the shared multiplier code, then eight stages for the three channel bytes in
// parallel, plus input, max, multiplier, saturation and output stages.
// Configuration: APB-style port, range_scale at byte address 0, 5 bits, pready always
// high; write it only while no item is in flight. A range of 0 acts as 1.
// Reset (rst_n low at a clock edge) clears all valid bits and sets range_scale to 9;
// items inside the pipeline are dropped.
module rgbm_hdr_pixel_encoder_top #(
  parameter int FRAC_BITS = rgbm_pkg::FRAC_BITS_DEF,
  parameter int INT_BITS  = rgbm_pkg::INT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              start,
  output logic                              busy,
  input  logic [INT_BITS+FRAC_BITS-1:0]     in_red_in,
  input  logic [INT_BITS+FRAC_BITS-1:0]     in_green_in,
  input  logic [INT_BITS+FRAC_BITS-1:0]     in_blue_in,
  // result channel
  output logic                              out_strobe,
  output logic [rgbm_pkg::CODE_W-1:0]       out_red_out,
  output logic [rgbm_pkg::CODE_W-1:0]       out_green_out,
  output logic [rgbm_pkg::CODE_W-1:0]       out_blue_out,
  output logic [rgbm_pkg::CODE_W-1:0]       out_multiplier_out,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rgbm_pkg::ADDR_W-1:0]       paddr,
  input  logic [rgbm_pkg::DATA_W-1:0]       pwdata,
  output logic [rgbm_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  localparam int IN_W  = INT_BITS + FRAC_BITS;
  localparam int CW    = rgbm_pkg::CODE_W;
  localparam int RW    = rgbm_pkg::RANGE_W;
  localparam int NCH   = rgbm_pkg::NCH;
  // multiplier divider: divisor range<<FRAC_BITS
  localparam int DW    = RW + FRAC_BITS;
  localparam int MW    = (IN_W > DW) ? IN_W : DW;
  localparam int NMX   = CW + MW + 1;
  localparam int NMW   = CW + DW;
  // channel divider: divisor (range*m)<<FRAC_BITS
  localparam int PW    = 2 * CW + IN_W;
  localparam int DCW   = RW + CW;
  localparam int CRW   = DCW + FRAC_BITS + CW;
  localparam int CXW   = (PW > CRW) ? PW : CRW;

  typedef logic [NCH-1:0][IN_W-1:0] pix_t;
  typedef logic [NCH-1:0][CRW-1:0]  crem_t;
  typedef logic [NCH-1:0][CW-1:0]   code3_t;

  // configuration register
  logic [RW-1:0] range_r;
  logic          reg_sel;
  logic [RW-1:0] rng;
  logic [DW-1:0] dm;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[rgbm_pkg::ADDR_W-1:2] == rgbm_pkg::REG_RANGE);
  assign prdata  = reg_sel ? rgbm_pkg::DATA_W'(range_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r <= rgbm_pkg::RANGE_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      range_r <= pwdata[RW-1:0];
    end
  end

  // effective range, zero treated as one
  assign rng = (range_r == '0) ? rgbm_pkg::RANGE_MIN : range_r;
  assign dm  = {rng, {FRAC_BITS{1'b0}}};

  assign busy = 1'b0;

  // input stage
  logic p0_v_r;
  pix_t p0_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_v_r <= 1'b0;
    end else begin
      p0_v_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    p0_pix_r <= {in_blue_in, in_green_in, in_red_in};
  end

  // max channel, multiplier saturation and ceil numerator
  logic [IN_W-1:0] mx;
  logic [NMX-1:0]  mnum;
  logic            msat;

  always_comb begin
    mx = p0_pix_r[0];
    if (p0_pix_r[1] > mx) mx = p0_pix_r[1];
    if (p0_pix_r[2] > mx) mx = p0_pix_r[2];
    msat = MW'(mx) > MW'(dm);
    mnum = NMX'(rgbm_pkg::CODE_MAX) * NMX'(mx) + NMX'(dm) - NMX'(1);
  end

  // multiplier divider, one quotient bit per stage
  logic           mv_r    [CW+1];
  logic           msat_r  [CW+1];
  logic [NMW-1:0] mrem_r  [CW+1];
  logic [CW-1:0]  mq_r    [CW+1];
  pix_t           mpix_r  [CW+1];
  logic [NMW-1:0] mrem_nxt[CW+1];
  logic [CW-1:0]  mq_nxt  [CW+1];
  logic [NMW-1:0] mtrial  [CW];

  always_comb begin
    mrem_nxt[0] = mnum[NMW-1:0];
    mq_nxt[0]   = '0;
    for (int j = 0; j < CW; j++) begin
      mtrial[j] = NMW'(dm) << (CW - 1 - j);
      if (mrem_r[j] >= mtrial[j]) begin
        mrem_nxt[j+1] = mrem_r[j] - mtrial[j];
        mq_nxt[j+1]   = mq_r[j] | (CW'(1) << (CW - 1 - j));
      end else begin
        mrem_nxt[j+1] = mrem_r[j];
        mq_nxt[j+1]   = mq_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= CW; j++) mv_r[j] <= 1'b0;
    end else begin
      mv_r[0] <= p0_v_r;
      for (int j = 0; j < CW; j++) mv_r[j+1] <= mv_r[j];
    end
  end

  always_ff @(posedge clk) begin
    msat_r[0] <= msat;
    mpix_r[0] <= p0_pix_r;
    for (int j = 0; j < CW; j++) begin
      msat_r[j+1] <= msat_r[j];
      mpix_r[j+1] <= mpix_r[j];
    end
    for (int j = 0; j <= CW; j++) begin
      mrem_r[j] <= mrem_nxt[j];
      mq_r[j]   <= mq_nxt[j];
    end
  end

  // multiplier code, channel divisor and channel numerators
  logic [CW-1:0]           mcode;
  logic                    mc_v_r;
  logic [CW-1:0]           mc_code_r;
  logic [DCW-1:0]          mc_den_r;
  logic [NCH-1:0][PW-1:0]  mc_num_r;

  always_comb begin
    if (msat_r[CW]) begin
      mcode = rgbm_pkg::CODE_MAX;
    end else if (mq_r[CW] == '0) begin
      mcode = rgbm_pkg::CODE_MIN;
    end else begin
      mcode = mq_r[CW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mc_v_r <= 1'b0;
    end else begin
      mc_v_r <= mv_r[CW];
    end
  end

  always_ff @(posedge clk) begin
    mc_code_r <= mcode;
    mc_den_r  <= DCW'(rng) * DCW'(mcode);
    for (int i = 0; i < NCH; i++) begin
      mc_num_r[i] <= PW'(rgbm_pkg::CODE_SQ) * PW'(mpix_r[CW][i]);
    end
  end

  // channel saturation check
  logic [CXW-1:0]          csat_lim;
  logic [NCH-1:0][CXW-1:0] cnum_x;
  logic [NCH-1:0]          csat;

  always_comb begin
    csat_lim = CXW'(mc_den_r) << (FRAC_BITS + CW);
    for (int i = 0; i < NCH; i++) begin
      cnum_x[i] = CXW'(mc_num_r[i]);
      csat[i]   = cnum_x[i] >= csat_lim;
    end
  end

  // channel dividers, three lanes, one quotient bit per stage
  logic           cv_r    [CW+1];
  logic [NCH-1:0] csat_r  [CW+1];
  crem_t          crem_r  [CW+1];
  code3_t         cq_r    [CW+1];
  logic [DCW-1:0] cden_r  [CW+1];
  logic [CW-1:0]  ccode_r [CW+1];
  crem_t          crem_nxt[CW+1];
  code3_t         cq_nxt  [CW+1];
  logic [CRW-1:0] ctrial  [CW];

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      crem_nxt[0][i] = cnum_x[i][CRW-1:0];
      cq_nxt[0][i]   = '0;
    end
    for (int j = 0; j < CW; j++) begin
      ctrial[j] = CRW'(cden_r[j]) << (FRAC_BITS + CW - 1 - j);
      for (int i = 0; i < NCH; i++) begin
        if (crem_r[j][i] >= ctrial[j]) begin
          crem_nxt[j+1][i] = crem_r[j][i] - ctrial[j];
          cq_nxt[j+1][i]   = cq_r[j][i] | (CW'(1) << (CW - 1 - j));
        end else begin
          crem_nxt[j+1][i] = crem_r[j][i];
          cq_nxt[j+1][i]   = cq_r[j][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= CW; j++) cv_r[j] <= 1'b0;
    end else begin
      cv_r[0] <= mc_v_r;
      for (int j = 0; j < CW; j++) cv_r[j+1] <= cv_r[j];
    end
  end

  always_ff @(posedge clk) begin
    csat_r[0]  <= csat;
    cden_r[0]  <= mc_den_r;
    ccode_r[0] <= mc_code_r;
    for (int j = 0; j < CW; j++) begin
      csat_r[j+1]  <= csat_r[j];
      cden_r[j+1]  <= cden_r[j];
      ccode_r[j+1] <= ccode_r[j];
    end
    for (int j = 0; j <= CW; j++) begin
      crem_r[j] <= crem_nxt[j];
      cq_r[j]   <= cq_nxt[j];
    end
  end

  // output register with byte saturation
  logic          out_v_r;
  code3_t        out_code_r;
  code3_t        out_code_nxt;
  logic [CW-1:0] out_m_r;

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      out_code_nxt[i] = csat_r[CW][i] ? rgbm_pkg::CODE_MAX : cq_r[CW][i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= cv_r[CW];
    end
  end

  always_ff @(posedge clk) begin
    out_code_r <= out_code_nxt;
    out_m_r    <= ccode_r[CW];
  end

  assign out_strobe         = out_v_r;
  assign out_red_out        = out_code_r[0];
  assign out_green_out      = out_code_r[1];
  assign out_blue_out       = out_code_r[2];
  assign out_multiplier_out = out_m_r;

endmodule
